// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file acpe_checker.sv.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ACPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ACPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/acpe_pkg.sv
// Shared types and constants of the autocorrelation pitch estimator.
// No dependencies; imported by every module of the block.
package acpe_pkg;

  localparam int MAX_LAGS   = 1024;
  localparam int LAG_W      = $clog2(MAX_LAGS + 1);
  localparam int COEF_W     = 24;
  localparam int RATIO_W    = 16;
  localparam int SR_W       = 18;
  localparam int PITCH_W    = 27;
  localparam int FIFO_DEPTH = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 18;

  // Back-end arithmetic widths
  localparam int GAM_W  = COEF_W + 3;            // 2v - n - p
  localparam int DNP_W  = COEF_W + 1;            // n - p
  localparam int DEN_W  = GAM_W + LAG_W + 3;     // +-(2gb + n - p), signed
  localparam int NUM_W  = SR_W + GAM_W - 1 + 9;  // sr * |g| * 512
  localparam int NUMR_W = NUM_W + 1;             // plus rounding half
  localparam int REM_W  = DEN_W - 1;

  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_RATIO = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE     = 1'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd32768;
  localparam logic [SR_W-1:0]    SR_RESET    = 18'd44100;

  localparam logic signed [COEF_W-1:0] CONF_ONE       = 24'sd4194304;
  localparam logic [PITCH_W-1:0]       PITCH_ALL_ONES = {PITCH_W{1'b1}};

  // search phases
  localparam logic [1:0] PH_DIP   = 2'd0;
  localparam logic [1:0] PH_BEGIN = 2'd1;
  localparam logic [1:0] PH_PEAK  = 2'd2;
  localparam logic [1:0] PH_END   = 2'd3;

  // One frame's outcome, handed from the scanner to the divider side.
  typedef struct packed {
    logic                     found;
    logic signed [COEF_W-1:0] conf;
    logic signed [COEF_W-1:0] peak_value;
    logic signed [COEF_W-1:0] before_peak;
    logic signed [COEF_W-1:0] after_peak;
    logic [LAG_W-1:0]         peak_lag;
  } summary_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// File: hw/rtl/acpe_scan.sv
// Front end: scans coefficients of a frame and tracks dip / peak state.
// Depends on acpe_pkg; pushes one summary per frame into the queue.
module acpe_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  logic signed [acpe_pkg::COEF_W-1:0]  coef,
  input  logic                                last,
  input  logic [acpe_pkg::RATIO_W-1:0]        ratio,
  output logic                                push,
  output acpe_pkg::summary_t                  push_data
);
  import acpe_pkg::*;

  logic [LAG_W-1:0]         lag_r, lag_nxt;
  logic [1:0]               phase_r, phase_nxt;
  logic signed [COEF_W-1:0] thr_r, thr_nxt;
  logic signed [COEF_W-1:0] pv_r, pv_nxt;
  logic [LAG_W-1:0]         pl_r, pl_nxt;
  logic signed [COEF_W-1:0] bp_r, bp_nxt;
  logic signed [COEF_W-1:0] ap_r, ap_nxt;
  logic signed [COEF_W-1:0] prev_r, prev_nxt;
  logic signed [COEF_W-1:0] wide_r, wide_nxt;
  logic                     dip_r, dip_nxt;

  logic signed [COEF_W+RATIO_W:0] thr_prod;
  logic                           after_lag;

  // floor(c0 * ratio / 65536): arithmetic shift floors negatives
  assign thr_prod  = coef * $signed({1'b0, ratio});
  assign after_lag = (lag_r == pl_r + LAG_W'(1));

  always_comb begin
    lag_nxt   = lag_r;
    phase_nxt = phase_r;
    thr_nxt   = thr_r;
    pv_nxt    = pv_r;
    pl_nxt    = pl_r;
    bp_nxt    = bp_r;
    ap_nxt    = ap_r;
    prev_nxt  = prev_r;
    wide_nxt  = wide_r;
    dip_nxt   = dip_r;
    if (lag_r < LAG_W'(MAX_LAGS)) begin
      if (lag_r == '0) begin
        thr_nxt = thr_prod[RATIO_W +: COEF_W];
      end else begin
        case (phase_r)
          PH_DIP: begin
            if (coef < thr_r) begin
              phase_nxt = PH_BEGIN;
              dip_nxt   = 1'b1;
              wide_nxt  = coef;
            end
          end
          PH_BEGIN: begin
            if (coef > wide_r) wide_nxt = coef;
            if (coef > thr_r) begin
              phase_nxt = PH_PEAK;
              pv_nxt    = coef;
              pl_nxt    = lag_r;
              bp_nxt    = prev_r;
            end
          end
          PH_PEAK: begin
            if (coef < thr_r) begin
              if (after_lag) ap_nxt = coef;
              phase_nxt = PH_END;
            end else begin
              if (coef > wide_r) wide_nxt = coef;
              if (coef > pv_r) begin
                pv_nxt = coef;
                pl_nxt = lag_r;
                bp_nxt = prev_r;
              end else if (after_lag) begin
                ap_nxt = coef;
              end
            end
          end
          default: ;
        endcase
      end
      prev_nxt = coef;
      lag_nxt  = lag_r + LAG_W'(1);
    end
  end

  // A peak counts only if it ended before the flagged coefficient.
  always_comb begin
    push                  = in_fire && last;
    push_data.found       = (phase_r == PH_END);
    push_data.peak_value  = pv_r;
    push_data.before_peak = bp_r;
    push_data.after_peak  = ap_r;
    push_data.peak_lag    = pl_r;
    if (phase_r == PH_END)
      push_data.conf = (pv_r > CONF_ONE) ? CONF_ONE : pv_r;
    else
      push_data.conf = dip_nxt ? wide_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last)) begin
      lag_r   <= '0;
      phase_r <= PH_DIP;
      thr_r   <= '0;
      pv_r    <= '0;
      pl_r    <= '0;
      bp_r    <= '0;
      ap_r    <= '0;
      prev_r  <= '0;
      wide_r  <= '0;
      dip_r   <= 1'b0;
    end else if (in_fire) begin
      lag_r   <= lag_nxt;
      phase_r <= phase_nxt;
      thr_r   <= thr_nxt;
      pv_r    <= pv_nxt;
      pl_r    <= pl_nxt;
      bp_r    <= bp_nxt;
      ap_r    <= ap_nxt;
      prev_r  <= prev_nxt;
      wide_r  <= wide_nxt;
      dip_r   <= dip_nxt;
    end
  end

endmodule

// File: hw/rtl/acpe_fifo.sv
// Short register queue of frame summaries between scanner and divider side.
// Depends on acpe_pkg for summary_t and FIFO_DEPTH.
module acpe_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  acpe_pkg::summary_t    push_data,
  input  logic                  pop,
  output acpe_pkg::summary_t    head,
  output acpe_pkg::fifo_stat_t  stat
);
  import acpe_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  summary_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign head       = mem_r[rd_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)
        wr_r <= (wr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (pop)
        rd_r <= (rd_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (push && !pop)
        cnt_r <= cnt_r + CNT_W'(1);
      else if (pop && !push)
        cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/acpe_pitch.sv
// Back end: parabolic refinement and pitch division, plus output register.
// Depends on acpe_pkg; takes frame summaries from acpe_fifo.
module acpe_pitch (
  input  logic                           clk,
  input  logic                           rst_n,
  input  acpe_pkg::summary_t             head,
  input  acpe_pkg::fifo_stat_t           stat,
  output logic                           pop,
  input  logic [acpe_pkg::SR_W-1:0]      sample_rate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [acpe_pkg::PITCH_W-1:0]   pitch,
  output logic signed [acpe_pkg::COEF_W-1:0] conf,
  output logic                           found
);
  import acpe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULT = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam int         CNT_W  = $clog2(PITCH_W + 1);

  logic [2:0]               st_r, st_nxt;
  summary_t                 hd_r;
  logic signed [GAM_W-1:0]  g_r;
  logic signed [DNP_W-1:0]  dnp_r;
  logic [NUM_W-1:0]         num_r;
  logic signed [DEN_W-1:0]  den_r;
  logic                     sat_r;
  logic [REM_W-1:0]         rem_r;
  logic [PITCH_W-1:0]       q_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;
  logic [PITCH_W-1:0]       pitch_r;
  logic signed [COEF_W-1:0] conf_r;
  logic                     found_r;

  logic signed [GAM_W-1:0]     g_c;
  logic signed [GAM_W+LAG_W:0] gb;
  logic signed [DEN_W-1:0]     den_raw;
  logic [GAM_W-2:0]            gabs;
  logic [SR_W+GAM_W-2:0]       sr_g;
  logic [NUMR_W-1:0]           numr;
  logic                        ovf;
  logic [REM_W:0]              trial;
  logic                        take;
  logic                        out_free;

  assign g_c = ({{3{head.peak_value[COEF_W-1]}}, head.peak_value} <<< 1)
             - {{3{head.after_peak[COEF_W-1]}}, head.after_peak}
             - {{3{head.before_peak[COEF_W-1]}}, head.before_peak};

  assign gb      = g_r * $signed({1'b0, hd_r.peak_lag});
  assign den_raw = (DEN_W'(gb) <<< 1) + DEN_W'(dnp_r);
  assign gabs    = g_r[GAM_W-1] ? (GAM_W-1)'(-g_r) : g_r[GAM_W-2:0];
  assign sr_g    = sample_rate * gabs;

  assign numr  = NUMR_W'(num_r) + NUMR_W'(den_r[DEN_W-1:1]);
  assign ovf   = ({(PITCH_W + DEN_W - NUMR_W)'(0), numr}
                  >= {den_r, {PITCH_W{1'b0}}});
  assign trial = {rem_r, q_r[PITCH_W-1]};
  assign take  = (trial >= REM_W'(den_r) + (REM_W + 1)'(0));

  assign out_free  = !out_valid_r || out_ready;
  assign pop       = (st_r == S_IDLE) && !stat.empty;
  assign out_valid = out_valid_r;
  assign pitch     = pitch_r;
  assign conf      = conf_r;
  assign found     = found_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (!stat.empty) st_nxt = head.found ? S_MULT : S_DONE;
      S_MULT: st_nxt = S_PREP;
      S_PREP: st_nxt = (sat_r || den_r <= 0 || ovf) ? S_DONE : S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(PITCH_W - 1)) st_nxt = S_DONE;
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  // q_r carries the pitch for the not-found and saturated cases too.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        hd_r  <= head;
        g_r   <= g_c;
        dnp_r <= {head.after_peak[COEF_W-1], head.after_peak}
               - {head.before_peak[COEF_W-1], head.before_peak};
        q_r   <= PITCH_ALL_ONES;
      end
      S_MULT: begin
        if (g_r == '0) begin
          num_r <= NUM_W'({sample_rate, 8'd0});
          den_r <= DEN_W'({1'b0, hd_r.peak_lag});
          sat_r <= (hd_r.peak_lag == '0);
        end else begin
          num_r <= {sr_g, 9'd0};
          den_r <= g_r[GAM_W-1] ? -den_raw : den_raw;
          sat_r <= 1'b0;
        end
      end
      S_PREP: begin
        cnt_r <= '0;
        rem_r <= REM_W'(numr[NUMR_W-1:PITCH_W]);
        if (sat_r || den_r == '0 || ovf) q_r <= PITCH_ALL_ONES;
        else if (den_r < 0)              q_r <= '0;
        else                             q_r <= numr[PITCH_W-1:0];
      end
      S_DIV: begin
        cnt_r <= cnt_r + CNT_W'(1);
        rem_r <= take ? REM_W'(trial - (REM_W + 1)'(den_r)) : REM_W'(trial);
        q_r   <= {q_r[PITCH_W-2:0], take};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DONE && out_free) begin
      pitch_r <= hd_r.found ? q_r : PITCH_ALL_ONES;
      conf_r  <= hd_r.conf;
      found_r <= hd_r.found;
    end
  end

endmodule

// File: hw/rtl/autocorrelation_pitch_estimator.sv
// Autocorrelation pitch estimator, top level: config registers and the three parts.
// Depends on acpe_pkg, acpe_scan, acpe_fifo, acpe_pitch.
// Throughput: one coefficient per cycle while the summary queue has room.
// Result path: after the flagged coefficient the summary passes the queue and the states
// IDLE, MULT, PREP, DIV (restoring divider), DONE; saturation skips DIV, no peak skips to DONE.
// Reset: synchronous active-low rst_n clears the scan state, queue and output.
module autocorrelation_pitch_estimator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [23:0]                           in_tdata,  // [23:0] coefficient
  input  logic                                  in_tlast,  // last_lag
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [55:0]                           out_tdata, // [26:0] pitch_fixed, [50:27] confidence
  output logic                                  out_tuser, // [0] pitch_found
  input  logic                                  cfg_we,
  input  logic [acpe_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [acpe_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import acpe_pkg::*;

  logic [RATIO_W-1:0]       ratio_r;
  logic [SR_W-1:0]          sr_r;
  logic                     in_fire;
  logic                     push, pop;
  summary_t                 push_data, head;
  fifo_stat_t               stat;
  logic [PITCH_W-1:0]       pitch;
  logic signed [COEF_W-1:0] conf;
  logic                     found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
      sr_r    <= SR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD_RATIO: ratio_r <= cfg_wdata[RATIO_W-1:0];
        REG_SAMPLE_RATE:     sr_r    <= cfg_wdata[SR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !stat.full;
  assign in_fire   = in_tvalid && in_tready;

  acpe_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .coef      ($signed(in_tdata)),
    .last      (in_tlast),
    .ratio     (ratio_r),
    .push      (push),
    .push_data (push_data)
  );

  acpe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  acpe_pitch u_pitch (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .stat        (stat),
    .pop         (pop),
    .sample_rate (sr_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .pitch       (pitch),
    .conf        (conf),
    .found       (found)
  );

  assign out_tdata = {5'd0, conf, pitch};
  assign out_tuser = found;

endmodule

// File: hw/rtl/acpe_checker.sv
// Port-level checks for the pitch estimator, bound to the top level.
// Depends on acpe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);
  import acpe_pkg::*;

  logic                     out_wait;
  logic                     out_nf;
  logic                     out_f;
  logic [PITCH_W-1:0]       pitch_f;
  logic signed [COEF_W-1:0] conf_f;

  assign out_wait = out_tvalid && !out_tready;
  assign out_nf   = out_tvalid && !out_tuser;
  assign out_f    = out_tvalid && out_tuser;
  assign pitch_f  = out_tdata[26:0];
  assign conf_f   = out_tdata[50:27];

  `ACPE_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_tdata), "held result changed")
  `ACPE_ASSERT_NOW(a_nf_ones, out_nf, pitch_f == PITCH_ALL_ONES, "not-found pitch not all ones")
  `ACPE_ASSERT_NOW(a_conf_clamp, out_f, conf_f <= CONF_ONE, "found confidence above 1.0")
  `ACPE_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[55:51] == 5'd0, "tdata padding not zero")

endmodule

bind autocorrelation_pitch_estimator acpe_checker u_acpe_checker (.*);

// File: tb/sv/autocorrelation_pitch_estimator_tb.sv
// Self-checking testbench for autocorrelation_pitch_estimator.
// Streams autocorrelation frames, predicts pitch/confidence per frame; needs acpe_pkg.
`timescale 1ns / 100ps

module autocorrelation_pitch_estimator_tb;
  import acpe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int FRAME_TARGET   = 60;

  typedef struct {
    logic [PITCH_W-1:0]       pitch;
    logic signed [COEF_W-1:0] conf;
    logic                     found;
  } pitch_result_t;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic                     last;
    logic                     typed;
    logic [PITCH_W-1:0]       pitch;
    logic signed [COEF_W-1:0] conf;
    logic                     found;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [55:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  autocorrelation_pitch_estimator dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [RATIO_W-1:0]       ratio_reg;
  logic [SR_W-1:0]          rate_reg;
  int unsigned              lag_cnt;
  logic [1:0]               phase;
  logic signed [COEF_W-1:0] thresh, pk_val, pk_before, pk_after, prev_coef, span_max;
  int unsigned              pk_lag, end_lag;
  logic                     dip_seen;

  pitch_result_t pitch_q[$];
  int            fail_cnt = 0;
  int            idle_cycles = 0;
  bit            long_hold = 0;

  function automatic void clear_frame_state();
    lag_cnt = 0; phase = PH_DIP; thresh = 0; pk_val = 0; pk_lag = 0;
    pk_before = 0; pk_after = 0; prev_coef = 0; span_max = 0; dip_seen = 0; end_lag = 0;
  endfunction

  function automatic longint pitch_of_peak();
    longint v, p, n, b, g, num, den, q;
    v = pk_val; p = pk_before; n = pk_after; b = pk_lag;
    g = 2 * v - n - p;
    if (g == 0) begin
      if (b <= 0) return PITCH_ALL_ONES;
      num = longint'(rate_reg) * 256;
      den = b;
    end else begin
      den = 2 * g * b + (n - p);
      num = longint'(rate_reg) * 512 * g;
      if (g < 0) begin
        den = -den;
        num = -num;
      end
      if (den == 0) return PITCH_ALL_ONES;
      if (den < 0) return 0;
    end
    q = (num + den / 2) / den;
    if (q > PITCH_ALL_ONES) q = PITCH_ALL_ONES;
    return q;
  endfunction

  // Advance the scan with one coefficient; returns 1 and fills res on frame end.
  function automatic bit scan_coef(input logic signed [COEF_W-1:0] c, input logic last,
                                   output pitch_result_t res);
    int unsigned lag;
    longint      prod;
    bit          found;
    lag = lag_cnt;
    if (lag < MAX_LAGS) begin
      if (lag == 0) begin
        prod = longint'(c) * longint'(ratio_reg);
        thresh = COEF_W'((prod >= 0) ? prod / 65536 : -((-prod + 65535) / 65536));
      end else if (phase == PH_DIP) begin
        if (c < thresh) begin
          phase = PH_BEGIN; dip_seen = 1; span_max = c;
        end
      end else if (phase == PH_BEGIN) begin
        if (c > span_max) span_max = c;
        if (c > thresh) begin
          phase = PH_PEAK; pk_val = c; pk_lag = lag; pk_before = prev_coef;
        end
      end else if (phase == PH_PEAK) begin
        if (c < thresh) begin
          if (lag == pk_lag + 1) pk_after = c;
          phase = PH_END; end_lag = lag;
        end else begin
          if (c > span_max) span_max = c;
          if (c > pk_val) begin
            pk_val = c; pk_lag = lag; pk_before = prev_coef;
          end else if (lag == pk_lag + 1) begin
            pk_after = c;
          end
        end
      end
      prev_coef = c;
      lag_cnt = lag + 1;
    end
    if (!last) return 0;
    found = (phase == PH_END) && (end_lag < lag);
    res.found = found;
    if (found) begin
      res.pitch = PITCH_W'(pitch_of_peak());
      res.conf = (pk_val > CONF_ONE) ? CONF_ONE : pk_val;
    end else begin
      res.pitch = PITCH_ALL_ONES;
      res.conf = dip_seen ? span_max : '0;
    end
    clear_frame_state();
    return 1;
  endfunction

  // Sender: one transaction, with bursty gaps.
  int burst_left = 0;
  task automatic send_coef(input logic signed [COEF_W-1:0] c, input logic last);
    pitch_result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (scan_coef(c, last, r)) pitch_q.push_back(r);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pitch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_THRESHOLD_RATIO) ratio_reg = val[RATIO_W-1:0];
    else rate_reg = val;
  endtask

  // Mostly well-formed frame: lag 0, repeating decay and bump, random outliers.
  task automatic send_random_frame();
    int len, period, k;
    logic signed [COEF_W-1:0] c0, c;
    len = $urandom_range(1, 40);
    period = $urandom_range(2, 12);
    c0 = $urandom_range(0, 7) == 0 ? COEF_W'($urandom) : COEF_W'($urandom_range(1, 4194304));
    for (k = 0; k < len; k++) begin
      if (k == 0) c = c0;
      else if ($urandom_range(0, 9) == 0) c = COEF_W'($urandom);
      else c = COEF_W'(longint'(c0) * (((k % period) * 2 - period) ** 2) / (period * period)
                       - longint'(c0) / 4 + $signed($urandom_range(0, 2000)) - 1000);
      send_coef(c, k == len - 1);
    end
  endtask

  // Receiver: stall pattern plus one long hold-off.
  always @(posedge clk) begin
    if (long_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Result checker.
  always @(posedge clk) begin
    pitch_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pitch_q.size() == 0) begin
        $error("result with no expectation waiting");
        fail_cnt++;
      end else begin
        e = pitch_q.pop_front();
        if (out_tdata[26:0] !== e.pitch) begin
          $error("pitch_fixed exp %0d got %0d", e.pitch, out_tdata[26:0]); fail_cnt++;
        end
        if (out_tdata[50:27] !== e.conf) begin
          $error("confidence exp %0d got %0d", e.conf, $signed(out_tdata[50:27])); fail_cnt++;
        end
        if (out_tuser !== e.found) begin
          $error("pitch_found exp %0d got %0d", e.found, out_tuser); fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n || long_hold)
      idle_cycles <= 0;
    else if (in_tvalid || pitch_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("autocorrelation_pitch_estimator_tb failed");
      $finish;
    end
  end

  stim_row_t directed[$];

  task automatic add_row(input logic signed [COEF_W-1:0] c, input logic last,
                         input logic typed = 0, input logic [PITCH_W-1:0] p = '0,
                         input logic signed [COEF_W-1:0] cf = '0, input logic f = 0);
    stim_row_t r;
    r.coef = c; r.last = last; r.typed = typed; r.pitch = p; r.conf = cf; r.found = f;
    directed.push_back(r);
  endtask

  initial begin
    pitch_result_t r;
    int frames;
    ratio_reg = RATIO_RESET;
    rate_reg  = SR_RESET;
    clear_frame_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single coefficient frame: not found, zero confidence
    add_row(24'sh7FFFFF, 1, 1, PITCH_ALL_ONES, 0, 0);
    // no dip: threshold of negative extreme lag 0
    add_row(-24'sd8388608, 0);
    add_row(24'sh7FFFFF, 1, 1, PITCH_ALL_ONES, 0, 0);
    // clean peak from lag 2 with a flat top
    add_row(24'sd4194304, 0); add_row(24'sd0, 0); add_row(24'sd3000000, 0);
    add_row(24'sd3000000, 0); add_row(24'sd0, 0); add_row(24'sd0, 1);
    // peak ends on final lag: not found, confidence from dip onward
    add_row(24'sd4194304, 0); add_row(-24'sd8388608, 0); add_row(24'sh7FFFFF, 0);
    add_row(24'sd0, 1, 1, PITCH_ALL_ONES, 24'sh7FFFFF, 0);
    // peak above 1.0 clamps confidence
    add_row(24'sd4194304, 0); add_row(24'sd10, 0); add_row(24'sh7FFFFF, 0);
    add_row(24'sd20, 0); add_row(24'sd5, 0); add_row(24'sd5, 1);
    // peak at lag 1 is not possible; dip then flat peak with ties
    add_row(24'sd1000, 0); add_row(-24'sd1, 0); add_row(24'sd900, 0);
    add_row(24'sd900, 0); add_row(-24'sd5, 1);
    foreach (directed[i]) begin
      send_coef(directed[i].coef, directed[i].last);
      if (directed[i].typed && directed[i].last) begin
        r = pitch_q[$];
        if (r.pitch !== directed[i].pitch) begin
          $error("row %0d pitch_fixed exp %0d got %0d", i, directed[i].pitch, r.pitch);
          fail_cnt++;
        end
        if (r.conf !== directed[i].conf) begin
          $error("row %0d confidence exp %0d got %0d", i, directed[i].conf, r.conf);
          fail_cnt++;
        end
        if (r.found !== directed[i].found) begin
          $error("row %0d pitch_found exp %0d got %0d", i, directed[i].found, r.found);
          fail_cnt++;
        end
      end
    end
    wait_drained();

    // Settings sweep, extremes included.
    frames = 0;
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'(0));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(1));
        end
        1: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'(65535));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(192000));
        end
        2: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'(32768));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(48000));
        end
        3: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'($urandom_range(0, 65535)));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'($urandom));
        end
        4: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'($urandom_range(16384, 60000)));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'($urandom_range(1, 192000)));
        end
        default: begin
          write_reg(REG_THRESHOLD_RATIO, CFG_DATA_W'(45000));
          write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(262143));
        end
      endcase
      for (int f = 0; f < FRAME_TARGET / 6; f++) begin
        if (s == 2 && f == 3) begin
          fork
            begin long_hold = 1; repeat (400) @(posedge clk); long_hold = 0; end
          join_none
        end
        send_random_frame();
        frames++;
      end
      wait_drained();
    end

    wait_drained();
    if (fail_cnt == 0 && pitch_q.size() == 0)
      $display("autocorrelation_pitch_estimator_tb passed");
    else
      $display("autocorrelation_pitch_estimator_tb failed");
    $finish;
  end

endmodule

// File: autocorrelation_pitch_estimator.f
+incdir+hw/rtl
hw/rtl/acpe_pkg.sv
hw/rtl/acpe_scan.sv
hw/rtl/acpe_fifo.sv
hw/rtl/acpe_pitch.sv
hw/rtl/autocorrelation_pitch_estimator.sv
hw/rtl/acpe_checker.sv
tb/sv/autocorrelation_pitch_estimator_tb.sv
